// ----- sv/tss_pkg.sv -----
// Shared types and constants for the time-slice task scheduler.
// No dependencies; used by tss_cell and time_slice_task_scheduler.
package tss_pkg;

   localparam int NUM_TASKS_DEF = 16;
   localparam int PRIO_W        = 8;
   localparam int SLICE_W       = 16;
   localparam int TASK_OUT_W    = 4;
   localparam int MULT_RESET    = 1;

   // Request codes on req_type
   typedef enum logic [1:0] {
      REQ_TICK   = 2'd0,
      REQ_CREATE = 2'd1,
      REQ_START  = 2'd2,
      REQ_NOP    = 2'd3
   } req_code_type;

   // Kind of pass travelling down the cell chain
   typedef enum logic [1:0] {
      OP_MAX    = 2'd0,
      OP_REFILL = 2'd1,
      OP_CREATE = 2'd2
   } scan_op_type;

   // Scan token handed from cell to cell
   typedef struct packed {
      logic                active;
      scan_op_type         op;
      logic                found;
      logic [SLICE_W-1:0]  top;
   } scan_type;

   // Controller states, one-hot
   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_DECODE = 3'b010,
      S_SCAN   = 3'b100
   } state_type;

endpackage

// ----- sv/tss_cell.sv -----
// One task slot of the scheduler chain: run flag, priority and slice,
// plus one registered stage of the scan token. Depends on tss_pkg.
module tss_cell #(
   parameter int NumTasks = tss_pkg::NUM_TASKS_DEF,
   parameter int CellIdx  = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tss_pkg::scan_type                 scan_in,
   input  logic [$clog2(NumTasks)-1:0]       best_in,
   output tss_pkg::scan_type                 scan_out,
   output logic [$clog2(NumTasks)-1:0]       best_out,
   input  logic                              dec,
   input  logic [tss_pkg::PRIO_W-1:0]        create_prio,
   input  logic [tss_pkg::PRIO_W-1:0]        mult,
   output logic [tss_pkg::SLICE_W-1:0]       slice
);

   localparam int IdxW = $clog2(NumTasks);
   localparam logic [IdxW-1:0] OwnIdx = IdxW'(CellIdx);

   logic                          runnable_ff, runnable_in;
   logic [tss_pkg::PRIO_W-1:0]    prio_ff, prio_in;
   logic [tss_pkg::SLICE_W-1:0]   slice_ff, slice_in;
   tss_pkg::scan_type             scan_ff, scan_in_n;
   logic [IdxW-1:0]               best_ff, best_in_n;
   logic [tss_pkg::SLICE_W-1:0]   prod;

   // Refill value for slots other than slot 0, wrapped to slice width
   assign prod = tss_pkg::SLICE_W'(prio_ff) * tss_pkg::SLICE_W'(mult);

   // Update slot state and pass the token along
   always_comb begin
      runnable_in = runnable_ff;
      prio_in     = prio_ff;
      slice_in    = slice_ff;
      scan_in_n   = scan_in;
      best_in_n   = best_in;
      if (scan_in.active) begin
         case (scan_in.op)
            tss_pkg::OP_MAX: begin
               if (runnable_ff && (slice_ff > scan_in.top)) begin
                  scan_in_n.top   = slice_ff;
                  scan_in_n.found = 1'b1;
                  best_in_n       = OwnIdx;
               end
            end
            tss_pkg::OP_REFILL: begin
               // slot 0 refills with its priority whether runnable or not
               if (CellIdx == 0) begin
                  slice_in      = tss_pkg::SLICE_W'(prio_ff);
                  scan_in_n.top = tss_pkg::SLICE_W'(prio_ff);
                  best_in_n     = OwnIdx;
               end else if (runnable_ff) begin
                  slice_in = prod;
                  if (prod > scan_in.top) begin
                     scan_in_n.top = prod;
                     best_in_n     = OwnIdx;
                  end
               end
            end
            tss_pkg::OP_CREATE: begin
               if (!scan_in.found && !runnable_ff) begin
                  runnable_in     = 1'b1;
                  prio_in         = create_prio;
                  slice_in        = tss_pkg::SLICE_W'(create_prio);
                  scan_in_n.found = 1'b1;
                  best_in_n       = OwnIdx;
               end
            end
            default: begin
            end
         endcase
      end else if (dec && (slice_ff != '0)) begin
         // take one unit, saturating at zero
         slice_in = slice_ff - tss_pkg::SLICE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         runnable_ff <= (CellIdx == 0);
         prio_ff     <= (CellIdx == 0) ? tss_pkg::PRIO_W'(1) : '0;
         slice_ff    <= (CellIdx == 0) ? tss_pkg::SLICE_W'(1) : '0;
         scan_ff     <= '0;
      end else begin
         runnable_ff <= runnable_in;
         prio_ff     <= prio_in;
         slice_ff    <= slice_in;
         scan_ff     <= scan_in_n;
      end
   end

   // Hold the best index alongside the token
   always_ff @(posedge clock) begin
      best_ff <= best_in_n;
   end

   assign scan_out = scan_ff;
   assign best_out = best_ff;
   assign slice    = slice_ff;

endmodule

// ----- sv/time_slice_task_scheduler.sv -----
// Top level of the time-slice task scheduler: controller and the row of
// task-slot cells. Depends on tss_pkg and tss_cell.
//
// One request is taken per start pulse while busy is low; exactly one
// result beat follows on rsp_strobe, which cannot be held off. A start,
// a no-op, a tick with no current task or a tick with slice left is
// decided in the decode state and its result beat is registered as the
// controller returns to idle; the next request can be taken in the same
// cycle as that beat. A create or a tick that must pick a new task sends
// a token down the row of NUM_TASKS cells, one cell per cycle. A tick
// that also refills all slices sends the token down twice. The refill
// multiplier is written through csr_wr_en and csr_wr_data; the user must
// write it only while the block is idle, as the block does not enforce it.
module time_slice_task_scheduler #(
   parameter int NUM_TASKS = tss_pkg::NUM_TASKS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_type,
   input  logic [tss_pkg::PRIO_W-1:0]          req_task_priority,
   input  logic [3:0]                          req_start_task,
   output logic                                rsp_strobe,
   output logic [tss_pkg::TASK_OUT_W-1:0]      rsp_running_task,
   output logic                                rsp_running_valid,
   output logic                                rsp_switched,
   output logic [tss_pkg::TASK_OUT_W-1:0]      rsp_created_slot,
   output logic                                rsp_table_full,
   input  logic                                csr_wr_en,
   input  logic [tss_pkg::PRIO_W-1:0]          csr_wr_data
);

   localparam int IdxW = $clog2(NUM_TASKS);
   localparam int OutW = tss_pkg::TASK_OUT_W;

   tss_pkg::state_type                state_ff, state_in;
   tss_pkg::req_code_type             req_code_ff;
   logic [tss_pkg::PRIO_W-1:0]        req_prio_ff;
   logic [3:0]                        req_start_ff;
   logic [IdxW-1:0]                   current_ff, current_in;
   logic                              current_set_ff, current_set_in;
   logic [tss_pkg::PRIO_W-1:0]        mult_ff;

   logic                              rsp_strobe_ff, rsp_strobe_in;
   logic [OutW-1:0]                   rsp_running_task_ff, rsp_running_task_in;
   logic                              rsp_running_valid_ff, rsp_running_valid_in;
   logic                              rsp_switched_ff, rsp_switched_in;
   logic [OutW-1:0]                   rsp_created_slot_ff, rsp_created_slot_in;
   logic                              rsp_table_full_ff, rsp_table_full_in;

   tss_pkg::scan_type                 scan_chain [NUM_TASKS+1];
   logic [IdxW-1:0]                   best_chain [NUM_TASKS+1];
   logic [tss_pkg::SLICE_W-1:0]       slices [NUM_TASKS];
   logic [NUM_TASKS-1:0]              dec_vec;
   logic                              dec_en;
   logic [IdxW-1:0]                   dec_idx;
   tss_pkg::scan_type                 launch_tok;
   tss_pkg::scan_type                 tail_tok;
   logic [IdxW-1:0]                   tail_best;
   logic [tss_pkg::SLICE_W-1:0]       cur_slice;

   assign busy      = (state_ff != tss_pkg::S_IDLE);
   assign tail_tok  = scan_chain[NUM_TASKS];
   assign tail_best = best_chain[NUM_TASKS];
   assign cur_slice = slices[current_ff];

   assign scan_chain[0] = launch_tok;
   assign best_chain[0] = '0;

   // Row of slot cells
   for (genvar k = 0; k < NUM_TASKS; k++) begin : g_cell
      assign dec_vec[k] = dec_en && (dec_idx == IdxW'(k));
      tss_cell #(
         .NumTasks (NUM_TASKS),
         .CellIdx  (k)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .scan_in     (scan_chain[k]),
         .best_in     (best_chain[k]),
         .scan_out    (scan_chain[k+1]),
         .best_out    (best_chain[k+1]),
         .dec         (dec_vec[k]),
         .create_prio (req_prio_ff),
         .mult        (mult_ff),
         .slice       (slices[k])
      );
   end

   // Sequence one request: decode, run passes, emit the result beat
   always_comb begin
      state_in            = state_ff;
      current_in          = current_ff;
      current_set_in      = current_set_ff;
      launch_tok          = '0;
      dec_en              = 1'b0;
      dec_idx             = current_ff;
      rsp_strobe_in       = 1'b0;
      rsp_switched_in     = 1'b0;
      rsp_created_slot_in = '0;
      rsp_table_full_in   = 1'b0;
      case (state_ff)
         tss_pkg::S_IDLE: begin
            if (start) begin
               state_in = tss_pkg::S_DECODE;
            end
         end
         tss_pkg::S_DECODE: begin
            case (req_code_ff)
               tss_pkg::REQ_TICK: begin
                  if (!current_set_ff) begin
                     rsp_strobe_in = 1'b1;
                     state_in      = tss_pkg::S_IDLE;
                  end else if (cur_slice != '0) begin
                     dec_en        = 1'b1;
                     rsp_strobe_in = 1'b1;
                     state_in      = tss_pkg::S_IDLE;
                  end else begin
                     launch_tok.active = 1'b1;
                     launch_tok.op     = tss_pkg::OP_MAX;
                     state_in          = tss_pkg::S_SCAN;
                  end
               end
               tss_pkg::REQ_CREATE: begin
                  launch_tok.active = 1'b1;
                  launch_tok.op     = tss_pkg::OP_CREATE;
                  state_in          = tss_pkg::S_SCAN;
               end
               tss_pkg::REQ_START: begin
                  if (32'(req_start_ff) < 32'(NUM_TASKS)) begin
                     current_in     = IdxW'(req_start_ff);
                     current_set_in = 1'b1;
                  end
                  rsp_strobe_in = 1'b1;
                  state_in      = tss_pkg::S_IDLE;
               end
               default: begin
                  rsp_strobe_in = 1'b1;
                  state_in      = tss_pkg::S_IDLE;
               end
            endcase
         end
         tss_pkg::S_SCAN: begin
            if (tail_tok.active) begin
               case (tail_tok.op)
                  tss_pkg::OP_CREATE: begin
                     rsp_created_slot_in = tail_tok.found ? OutW'(tail_best) : '0;
                     rsp_table_full_in   = !tail_tok.found;
                     rsp_strobe_in       = 1'b1;
                     state_in            = tss_pkg::S_IDLE;
                  end
                  default: begin
                     if ((tail_tok.op == tss_pkg::OP_MAX) && !tail_tok.found) begin
                        // nothing left to run: refill and choose on the way
                        launch_tok.active = 1'b1;
                        launch_tok.op     = tss_pkg::OP_REFILL;
                     end else begin
                        if (tail_best != current_ff) begin
                           current_in      = tail_best;
                           dec_en          = 1'b1;
                           dec_idx         = tail_best;
                           rsp_switched_in = 1'b1;
                        end
                        rsp_strobe_in = 1'b1;
                        state_in      = tss_pkg::S_IDLE;
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = tss_pkg::S_IDLE;
         end
      endcase
      rsp_running_valid_in = current_set_in;
      rsp_running_task_in  = current_set_in ? OutW'(current_in) : '0;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tss_pkg::S_IDLE;
         current_ff     <= '0;
         current_set_ff <= 1'b0;
         mult_ff        <= tss_pkg::PRIO_W'(tss_pkg::MULT_RESET);
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         current_ff     <= current_in;
         current_set_ff <= current_set_in;
         rsp_strobe_ff  <= rsp_strobe_in;
         if (csr_wr_en) begin
            mult_ff <= csr_wr_data;
         end
      end
   end

   // Capture the request beat and the result payload
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_code_ff  <= tss_pkg::req_code_type'(req_type);
         req_prio_ff  <= req_task_priority;
         req_start_ff <= req_start_task;
      end
      if (rsp_strobe_in) begin
         rsp_running_task_ff  <= rsp_running_task_in;
         rsp_running_valid_ff <= rsp_running_valid_in;
         rsp_switched_ff      <= rsp_switched_in;
         rsp_created_slot_ff  <= rsp_created_slot_in;
         rsp_table_full_ff    <= rsp_table_full_in;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_running_task  = rsp_running_task_ff;
   assign rsp_running_valid = rsp_running_valid_ff;
   assign rsp_switched      = rsp_switched_ff;
   assign rsp_created_slot  = rsp_created_slot_ff;
   assign rsp_table_full    = rsp_table_full_ff;

   // A result beat always lands as the controller returns to idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> (state_ff == tss_pkg::S_IDLE))
      else $error("result beat outside idle");

   // The token reaches the end of the row only during a pass
   assert property (@(posedge clock) disable iff (reset)
      tail_tok.active |-> (state_ff == tss_pkg::S_SCAN))
      else $error("stray scan token");

   // At most one slot loses a unit per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0(dec_vec))
      else $error("several slots decremented");

   // A switch always names a set current task and a different one
   assert property (@(posedge clock) disable iff (reset)
      rsp_switched_in |-> (current_set_ff && (current_in != current_ff)))
      else $error("switch without change of task");

   // A full table reports slot zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_table_full_ff) |-> (rsp_created_slot_ff == '0))
      else $error("full table with a slot number");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for time_slice_task_scheduler: a scheduler model
// predicts every response beat. Depends on tss_pkg and the scheduler RTL.
module tb_top;

   localparam int TASKS = tss_pkg::NUM_TASKS_DEF;

   typedef struct packed {
      tss_pkg::req_code_type kind;
      logic [7:0]            prio;
      logic [3:0]            task_id;
   } sched_req_type;

   typedef struct packed {
      logic [3:0] run_task;
      logic       run_valid;
      logic       switched;
      logic [3:0] slot;
      logic       full;
   } sched_rsp_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_type = tss_pkg::REQ_NOP;
   logic [7:0] req_task_priority = '0;
   logic [3:0] req_start_task = '0;
   logic       rsp_strobe;
   logic [3:0] rsp_running_task;
   logic       rsp_running_valid;
   logic       rsp_switched;
   logic [3:0] rsp_created_slot;
   logic       rsp_table_full;
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = '0;

   // Scheduler model state
   logic        slot_live [TASKS];
   logic [7:0]  slot_prio [TASKS];
   logic [15:0] slot_slice [TASKS];
   logic [3:0]  cur_task;
   logic        cur_valid;
   logic [7:0]  refill_mult;

   sched_req_type pending_req_q [$];
   sched_rsp_type expected_rsp_q [$];
   sched_req_type driven_req;
   int         burst_left = 1;
   int         gap_left = 0;
   int         creates_queued = 0;
   int         mismatch_count = 0;

   time_slice_task_scheduler u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_task_priority (req_task_priority),
      .req_start_task    (req_start_task),
      .rsp_strobe        (rsp_strobe),
      .rsp_running_task  (rsp_running_task),
      .rsp_running_valid (rsp_running_valid),
      .rsp_switched      (rsp_switched),
      .rsp_created_slot  (rsp_created_slot),
      .rsp_table_full    (rsp_table_full),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Apply one request to the model and return the response it must produce
   function automatic sched_rsp_type schedule_step(sched_req_type rq);
      sched_rsp_type r;
      logic [15:0] top;
      logic [3:0]  best;
      logic        found;
      r = '0;
      case (rq.kind)
         tss_pkg::REQ_TICK: begin
            if (cur_valid) begin
               if (slot_slice[cur_task] != 0) begin
                  slot_slice[cur_task] = slot_slice[cur_task] - 16'd1;
               end else begin
                  top = '0;
                  best = '0;
                  found = 1'b0;
                  // pick the runnable slot with the largest slice, lowest index on ties
                  for (int k = 0; k < TASKS; k++) begin
                     if (slot_live[k] && slot_slice[k] > top) begin
                        top = slot_slice[k];
                        best = 4'(k);
                        found = 1'b1;
                     end
                  end
                  // nothing left anywhere: refill, slot 0 without the multiplier
                  if (!found) begin
                     slot_slice[0] = 16'(slot_prio[0]);
                     top = slot_slice[0];
                     best = '0;
                     for (int k = 1; k < TASKS; k++) begin
                        if (slot_live[k]) begin
                           slot_slice[k] = 16'(slot_prio[k]) * 16'(refill_mult);
                           if (slot_slice[k] > top) begin
                              top = slot_slice[k];
                              best = 4'(k);
                           end
                        end
                     end
                  end
                  if (best != cur_task) begin
                     cur_task = best;
                     if (slot_slice[best] != 0) slot_slice[best] = slot_slice[best] - 16'd1;
                     r.switched = 1'b1;
                  end
               end
            end
         end
         tss_pkg::REQ_CREATE: begin
            r.full = 1'b1;
            for (int k = 0; k < TASKS; k++) begin
               if (r.full && !slot_live[k]) begin
                  slot_live[k] = 1'b1;
                  slot_prio[k] = rq.prio;
                  slot_slice[k] = 16'(rq.prio);
                  r.slot = 4'(k);
                  r.full = 1'b0;
               end
            end
         end
         tss_pkg::REQ_START: begin
            cur_task = rq.task_id;
            cur_valid = 1'b1;
         end
         default: ;
      endcase
      r.run_task = cur_valid ? cur_task : 4'd0;
      r.run_valid = cur_valid;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("%0t: MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic push_req(tss_pkg::req_code_type kind, logic [7:0] prio,
                           logic [3:0] task_id);
      sched_req_type rq;
      rq.kind = kind;
      rq.prio = prio;
      rq.task_id = task_id;
      if (kind == tss_pkg::REQ_CREATE) creates_queued++;
      pending_req_q.push_back(rq);
   endtask

   // Mostly tick runs with starts and creates mixed in; a few no-ops
   task automatic queue_random_reqs(int count);
      int queued;
      int pick;
      int run_len;
      logic [7:0] prio;
      queued = 0;
      while (queued < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            run_len = $urandom_range(1, 12);
            repeat (run_len) push_req(tss_pkg::REQ_TICK, 8'($urandom), 4'($urandom));
            queued += run_len;
         end else if (pick < 77) begin
            push_req(tss_pkg::REQ_START, 8'($urandom), 4'($urandom));
            queued++;
         end else if (pick < 92) begin
            // keep slices short while the table still has room
            if (creates_queued < TASKS - 1)
               prio = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(6, 20))
                                                   : 8'($urandom_range(0, 5));
            else
               prio = 8'($urandom);
            push_req(tss_pkg::REQ_CREATE, prio, 4'($urandom));
            queued++;
         end else begin
            push_req(tss_pkg::REQ_NOP, 8'($urandom), 4'($urandom));
         end
      end
   endtask

   // Hold until every request is accepted and every response has come back
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_req_q.size() != 0 || start || expected_rsp_q.size() != 0 || busy);
   endtask

   task automatic set_multiplier(logic [7:0] m);
      wait_idle();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      refill_mult = m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Driver: issue queued requests in bursts, hold each until it is taken
   always @(posedge clock) begin : drv
      sched_req_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) expected_rsp_q.push_back(schedule_step(driven_req));
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_req_q.size() != 0) begin
               nxt = pending_req_q.pop_front();
               driven_req = nxt;
               req_type <= nxt.kind;
               req_task_priority <= nxt.prio;
               req_start_task <= nxt.task_id;
               start <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
               end else begin
                  burst_left--;
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each response beat with the oldest prediction
   always @(posedge clock) begin : mon
      sched_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("response beat with nothing outstanding", 1, 0);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_running_task !== want.run_task)
               report_mismatch("running_task", rsp_running_task, want.run_task);
            if (rsp_running_valid !== want.run_valid)
               report_mismatch("running_valid", rsp_running_valid, want.run_valid);
            if (rsp_switched !== want.switched)
               report_mismatch("switched", rsp_switched, want.switched);
            if (rsp_created_slot !== want.slot)
               report_mismatch("created_slot", rsp_created_slot, want.slot);
            if (rsp_table_full !== want.full)
               report_mismatch("table_full", rsp_table_full, want.full);
         end
      end
   end

   initial begin
      for (int k = 0; k < TASKS; k++) begin
         slot_live[k] = 1'b0;
         slot_prio[k] = '0;
         slot_slice[k] = '0;
      end
      slot_live[0] = 1'b1;
      slot_prio[0] = 8'd1;
      slot_slice[0] = 16'd1;
      cur_task = '0;
      cur_valid = 1'b0;
      refill_mult = 8'(tss_pkg::MULT_RESET);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      set_multiplier(8'd1);

      // Directed: tick with no task, start on an empty slot, a refill that
      // keeps the same task, creates at the priority extremes, switches
      push_req(tss_pkg::REQ_TICK, 8'd0, 4'd0);
      push_req(tss_pkg::REQ_NOP, 8'd0, 4'd0);
      push_req(tss_pkg::REQ_START, 8'd0, 4'd5);
      push_req(tss_pkg::REQ_TICK, 8'd0, 4'd0);
      push_req(tss_pkg::REQ_TICK, 8'd0, 4'd0);
      push_req(tss_pkg::REQ_TICK, 8'd0, 4'd0);
      push_req(tss_pkg::REQ_CREATE, 8'd255, 4'd0);
      push_req(tss_pkg::REQ_CREATE, 8'd0, 4'd0);
      push_req(tss_pkg::REQ_CREATE, 8'd3, 4'd0);
      push_req(tss_pkg::REQ_TICK, 8'd0, 4'd0);
      push_req(tss_pkg::REQ_START, 8'd255, 4'd15);
      push_req(tss_pkg::REQ_START, 8'd0, 4'd3);
      repeat (4) push_req(tss_pkg::REQ_TICK, 8'd0, 4'd0);
      push_req(tss_pkg::REQ_START, 8'd0, 4'd2);
      push_req(tss_pkg::REQ_TICK, 8'd0, 4'd0);
      push_req(tss_pkg::REQ_NOP, 8'd255, 4'd15);
      push_req(tss_pkg::REQ_CREATE, 8'd1, 4'd15);
      push_req(tss_pkg::REQ_TICK, 8'd255, 4'd15);

      // Random phases across several multiplier settings, largest last
      queue_random_reqs(350);
      set_multiplier(8'($urandom_range(2, 9)));
      queue_random_reqs(350);
      set_multiplier(8'd0);
      queue_random_reqs(300);
      set_multiplier(8'd255);
      queue_random_reqs(250);

      wait_idle();
      repeat (40) @(posedge clock);
      if (expected_rsp_q.size() != 0)
         report_mismatch("responses never arrived", 0, 16'(expected_rsp_q.size()));
      if (mismatch_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5ms;
      $display("tb_top failed");
      $finish;
   end

endmodule
